/* rtl/adaptive_ema_position_smoother_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive EMA position smoother
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_EMA_POSITION_SMOOTHER_DEFINES_SVH
`define ADAPTIVE_EMA_POSITION_SMOOTHER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AEMS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smoother assertion failed (same cycle)");

// Consequent must hold in the cycle after the antecedent.
`define AEMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smoother assertion failed (next cycle)");

`endif

/* rtl/aems_pkg.sv */
// ----------------------------------------------------------------------------
// aems_pkg
// Types, widths and codes shared by the adaptive EMA position smoother.
// ----------------------------------------------------------------------------
package aems_pkg;

    localparam int COORD_BITS  = 16;
    localparam int WEIGHT_BITS = 16;

    // Shared multiplier: 17 x 17 bits covers the complement weight 2^16 - w.
    localparam int MUL_W  = WEIGHT_BITS + 1;
    localparam int PROD_W = 2 * MUL_W;

    // Shift-subtract unit widths.
    localparam int OPND_W = 34;
    localparam int REM_W  = 20;
    localparam int RES_W  = 32;
    localparam int STEP_W = 6;

    localparam logic [STEP_W-1:0] SQRT_STEPS = 6'd17;
    localparam logic [STEP_W-1:0] DIV_STEPS  = 6'd32;

    // Configuration port.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAPID_THRESHOLD = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WEIGHT      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WEIGHT      = 8'd3;

    localparam logic [15:0] NOISE_RESET = 16'd80;
    localparam logic [15:0] RAPID_RESET = 16'd400;
    localparam logic [15:0] MINW_RESET  = 16'd6554;
    localparam logic [15:0] MAXW_RESET  = 16'd26214;

    localparam logic [15:0] FIRST_FIX_WEIGHT = 16'hFFFF;
    localparam logic [MUL_W-1:0] WEIGHT_ONE = 17'h10000;
    localparam logic [32:0] ROUND_HALF = 33'h0_0000_8000;

    typedef enum logic
    {
        MODE_DIV,
        MODE_SQRT
    } shsub_mode_t;

    typedef struct packed
    {
        logic        start;
        shsub_mode_t mode;
    } shsub_cmd_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } shsub_status_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_DIFF,
        S_MX,
        S_MY,
        S_SUM,
        S_SQRT,
        S_PICK,
        S_NUM,
        S_DIV,
        S_ROUND,
        S_B0,
        S_B1,
        S_B2,
        S_B3,
        S_B4,
        S_EMIT
    } state_t;

endpackage

/* rtl/aems_mul.sv */
// ----------------------------------------------------------------------------
// aems_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module aems_mul
(
    input  logic                             clk,
    input  logic [aems_pkg::MUL_W-1:0]       mul_a,
    input  logic [aems_pkg::MUL_W-1:0]       mul_b,
    output logic [aems_pkg::PROD_W-1:0]      prod
);

    logic [aems_pkg::PROD_W-1:0] prod_reg;
    logic [aems_pkg::PROD_W-1:0] prod_next;

    always_comb
    begin
        prod_next = mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

/* rtl/aems_shsub.sv */
// ----------------------------------------------------------------------------
// aems_shsub
// Iterative shift-subtract unit: restoring square root or long division.
// ----------------------------------------------------------------------------
`include "adaptive_ema_position_smoother_defines.svh"

module aems_shsub
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  aems_pkg::shsub_cmd_t          cmd,
    input  logic [aems_pkg::OPND_W-1:0]   opnd,
    input  logic [15:0]                   divisor,
    output logic [aems_pkg::RES_W-1:0]    result,
    output logic [15:0]                   remainder,
    output aems_pkg::shsub_status_t       status
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [aems_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    aems_pkg::shsub_mode_t        mode_reg, mode_next;
    logic [aems_pkg::OPND_W-1:0]  opnd_reg, opnd_next;
    logic [15:0]                  divisor_reg, divisor_next;
    logic [aems_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic [aems_pkg::RES_W-1:0]   res_reg, res_next;

    logic [aems_pkg::REM_W-1:0]   rem_sh;
    logic [aems_pkg::REM_W-1:0]   trial;
    logic [aems_pkg::REM_W:0]     diff;
    logic                         take;

    // One compare-subtract serves both operations; only the operands differ.
    always_comb
    begin
        if (mode_reg == aems_pkg::MODE_SQRT)
        begin
            rem_sh = {rem_reg[aems_pkg::REM_W-3:0], opnd_reg[aems_pkg::OPND_W-1 -: 2]};
            trial  = {res_reg[aems_pkg::REM_W-3:0], 2'b01};
        end
        else
        begin
            rem_sh = {rem_reg[aems_pkg::REM_W-2:0], opnd_reg[aems_pkg::OPND_W-1]};
            trial  = {4'b0000, divisor_reg};
        end
        diff = {1'b0, rem_sh} - {1'b0, trial};
        take = ~diff[aems_pkg::REM_W];
    end

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        mode_next    = mode_reg;
        opnd_next    = opnd_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        res_next     = res_reg;
        if (cmd.start)
        begin
            busy_next    = 1'b1;
            mode_next    = cmd.mode;
            opnd_next    = opnd;
            divisor_next = divisor;
            rem_next     = '0;
            res_next     = '0;
            cnt_next     = (cmd.mode == aems_pkg::MODE_SQRT) ? aems_pkg::SQRT_STEPS
                                                             : aems_pkg::DIV_STEPS;
        end
        else if (busy_reg)
        begin
            rem_next = take ? diff[aems_pkg::REM_W-1:0] : rem_sh;
            res_next = {res_reg[aems_pkg::RES_W-2:0], take};
            if (mode_reg == aems_pkg::MODE_SQRT)
            begin
                opnd_next = {opnd_reg[aems_pkg::OPND_W-3:0], 2'b00};
            end
            else
            begin
                opnd_next = {opnd_reg[aems_pkg::OPND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= aems_pkg::MODE_DIV;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opnd_reg    <= opnd_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        res_reg     <= res_next;
    end

    assign result      = res_reg;
    assign remainder   = rem_reg[15:0];
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    `AEMS_ASSERT_NOW(a_no_start_while_busy, cmd.start, !busy_reg)
    `AEMS_ASSERT_NEXT(a_done_after_last_step, busy_reg && !cmd.start && (cnt_reg == 6'd1),
        done_reg && !busy_reg)
    `AEMS_ASSERT_NOW(a_root_width, done_reg && (mode_reg == aems_pkg::MODE_SQRT),
        res_reg[aems_pkg::RES_W-1:17] == '0)
    `AEMS_ASSERT_NOW(a_div_rem_below_divisor,
        done_reg && (mode_reg == aems_pkg::MODE_DIV) && (divisor_reg != 16'd0),
        rem_reg < {4'b0000, divisor_reg})

endmodule

/* rtl/adaptive_ema_position_smoother.sv */
// ----------------------------------------------------------------------------
// adaptive_ema_position_smoother
// Adaptive two-dimensional exponential smoother for a tracked target centre.
// ----------------------------------------------------------------------------
// One detected centre (unsigned Q12.4 pixels) is taken per input transfer,
// with a found flag in tuser. A transfer without a detection is taken and
// produces nothing. The first detection after reset is passed straight
// through with a weight of 0xFFFF and first_fix set. Every later detection
// is blended with the stored centre using a Q0.16 weight chosen from the
// Euclidean distance between the two, and the blended centre is stored and
// sent out. A tracked detection passes through the difference, the two
// squares in the shared multiplier and the 17-step square root in the shared
// shift-subtract unit; when the distance falls inside the thresholds the
// weight is then interpolated with a 32-step division in the same unit,
// and the blend takes four products in the shared multiplier. The input is
// not ready while an item is being worked on. A finished result waits in the
// output register, and the block goes back to accepting input as soon as it
// has been loaded there. Configuration writes are always ready and should be
// made only while the block is idle.
// ----------------------------------------------------------------------------
module adaptive_ema_position_smoother
(
    input  logic                               clk,
    input  logic                               rst_n,

    // Input stream. tdata: det_x [15:0], det_y [31:16]. tuser: found [0].
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [31:0]                        s_axis_tdata,
    input  logic                               s_axis_tuser,

    // Result stream. tdata: center_x [15:0], center_y [31:16],
    // weight_used [47:32]. tuser: first_fix [0].
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [47:0]                        m_axis_tdata,
    output logic                               m_axis_tuser,

    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [aems_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                        cfg_data
);

    // Sequencer state.
    aems_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic [15:0] noise_reg, rapid_reg, minw_reg, maxw_reg;

    // Tracker state.
    logic        have_stored_reg, have_stored_next;
    logic [15:0] stored_x_reg, stored_x_next;
    logic [15:0] stored_y_reg, stored_y_next;

    // Working registers for the item in flight.
    logic [15:0] x_reg, x_next;
    logic [15:0] y_reg, y_next;
    logic [15:0] dx_reg, dx_next;
    logic [15:0] dy_reg, dy_next;
    logic [32:0] acc_reg, acc_next;
    logic [15:0] den_reg, den_next;
    logic        up_reg, up_next;
    logic [15:0] w_reg, w_next;
    logic [15:0] nx_reg, nx_next;
    logic [15:0] ny_reg, ny_next;
    logic        ff_reg, ff_next;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [15:0] out_x_reg, out_x_next;
    logic [15:0] out_y_reg, out_y_next;
    logic [15:0] out_w_reg, out_w_next;
    logic        out_ff_reg, out_ff_next;

    // Shared units.
    logic [aems_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic [aems_pkg::PROD_W-1:0] prod;
    aems_pkg::shsub_cmd_t        unit_cmd;
    aems_pkg::shsub_status_t     unit_status;
    logic [aems_pkg::OPND_W-1:0] unit_opnd;
    logic [aems_pkg::RES_W-1:0]  unit_res;
    logic [15:0]                 unit_rem;

    // Derived values.
    logic        in_accept;
    logic        out_free;
    logic [15:0] det_x, det_y;
    logic        found;
    logic [16:0] distance;
    logic [15:0] offset;
    logic [15:0] span_w;
    logic [15:0] span_d;
    logic        at_min;
    logic        at_max;
    logic [32:0] sum_sq;
    logic [32:0] blend_sum;
    logic [16:0] q_rounded;
    logic        round_up;

    logic [aems_pkg::MUL_W-1:0] cw;

    assign det_x     = s_axis_tdata[15:0];
    assign det_y     = s_axis_tdata[31:16];
    assign found     = s_axis_tuser;
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !m_valid_reg || m_axis_tready;

    assign distance = unit_res[16:0];
    assign offset   = distance[15:0] - noise_reg;
    assign span_d   = rapid_reg - noise_reg;
    assign span_w   = (maxw_reg >= minw_reg) ? (maxw_reg - minw_reg) : (minw_reg - maxw_reg);
    assign at_min   = distance <= {1'b0, noise_reg};
    assign at_max   = (rapid_reg <= noise_reg) || (distance >= {1'b0, rapid_reg});

    assign sum_sq    = acc_reg + {1'b0, prod[31:0]};
    assign blend_sum = acc_reg + prod[32:0];
    assign cw        = aems_pkg::WEIGHT_ONE - {1'b0, w_reg};

    // Round to nearest, ties upward, from the quotient and remainder.
    assign round_up  = {unit_rem, 1'b0} >= {1'b0, den_reg};
    assign q_rounded = {1'b0, unit_res[15:0]} + {16'd0, round_up};

    // ------------------------------------------------------------------------
    // Sequencer: next state and unit controls.
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        s_axis_tready  = 1'b0;
        unit_cmd.start = 1'b0;
        unit_cmd.mode  = aems_pkg::MODE_DIV;
        unit_opnd      = '0;
        mul_a          = '0;
        mul_b          = '0;
        case (state_reg)
            aems_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_accept && found)
                begin
                    state_next = have_stored_reg ? aems_pkg::S_DIFF : aems_pkg::S_EMIT;
                end
            end
            aems_pkg::S_DIFF:
            begin
                state_next = aems_pkg::S_MX;
            end
            aems_pkg::S_MX:
            begin
                mul_a      = {1'b0, dx_reg};
                mul_b      = {1'b0, dx_reg};
                state_next = aems_pkg::S_MY;
            end
            aems_pkg::S_MY:
            begin
                mul_a      = {1'b0, dy_reg};
                mul_b      = {1'b0, dy_reg};
                state_next = aems_pkg::S_SUM;
            end
            aems_pkg::S_SUM:
            begin
                unit_cmd.start = 1'b1;
                unit_cmd.mode  = aems_pkg::MODE_SQRT;
                unit_opnd      = {1'b0, sum_sq};
                state_next     = aems_pkg::S_SQRT;
            end
            aems_pkg::S_SQRT:
            begin
                if (unit_status.done)
                begin
                    state_next = aems_pkg::S_PICK;
                end
            end
            aems_pkg::S_PICK:
            begin
                mul_a = {1'b0, offset};
                mul_b = {1'b0, span_w};
                if (at_min || at_max)
                begin
                    state_next = aems_pkg::S_B0;
                end
                else
                begin
                    state_next = aems_pkg::S_NUM;
                end
            end
            aems_pkg::S_NUM:
            begin
                unit_cmd.start = 1'b1;
                unit_cmd.mode  = aems_pkg::MODE_DIV;
                unit_opnd      = {prod[31:0], 2'b00};
                state_next     = aems_pkg::S_DIV;
            end
            aems_pkg::S_DIV:
            begin
                if (unit_status.done)
                begin
                    state_next = aems_pkg::S_ROUND;
                end
            end
            aems_pkg::S_ROUND:
            begin
                state_next = aems_pkg::S_B0;
            end
            aems_pkg::S_B0:
            begin
                mul_a      = {1'b0, w_reg};
                mul_b      = {1'b0, x_reg};
                state_next = aems_pkg::S_B1;
            end
            aems_pkg::S_B1:
            begin
                mul_a      = cw;
                mul_b      = {1'b0, stored_x_reg};
                state_next = aems_pkg::S_B2;
            end
            aems_pkg::S_B2:
            begin
                mul_a      = {1'b0, w_reg};
                mul_b      = {1'b0, y_reg};
                state_next = aems_pkg::S_B3;
            end
            aems_pkg::S_B3:
            begin
                mul_a      = cw;
                mul_b      = {1'b0, stored_y_reg};
                state_next = aems_pkg::S_B4;
            end
            aems_pkg::S_B4:
            begin
                state_next = aems_pkg::S_EMIT;
            end
            aems_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = aems_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = aems_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Datapath next values.
    // ------------------------------------------------------------------------
    always_comb
    begin
        x_next           = x_reg;
        y_next           = y_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        acc_next         = acc_reg;
        den_next         = den_reg;
        up_next          = up_reg;
        w_next           = w_reg;
        nx_next          = nx_reg;
        ny_next          = ny_reg;
        ff_next          = ff_reg;
        have_stored_next = have_stored_reg;
        stored_x_next    = stored_x_reg;
        stored_y_next    = stored_y_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_w_next       = out_w_reg;
        out_ff_next      = out_ff_reg;
        case (state_reg)
            aems_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    // The first fix goes out exactly as given.
                    x_next  = det_x;
                    y_next  = det_y;
                    nx_next = det_x;
                    ny_next = det_y;
                    w_next  = aems_pkg::FIRST_FIX_WEIGHT;
                    ff_next = !have_stored_reg;
                end
            end
            aems_pkg::S_DIFF:
            begin
                dx_next = (x_reg >= stored_x_reg) ? (x_reg - stored_x_reg)
                                                  : (stored_x_reg - x_reg);
                dy_next = (y_reg >= stored_y_reg) ? (y_reg - stored_y_reg)
                                                  : (stored_y_reg - y_reg);
            end
            aems_pkg::S_MY:
            begin
                acc_next = {1'b0, prod[31:0]};
            end
            aems_pkg::S_PICK:
            begin
                den_next = span_d;
                up_next  = maxw_reg >= minw_reg;
                if (at_min)
                begin
                    w_next = minw_reg;
                end
                else if (at_max)
                begin
                    w_next = maxw_reg;
                end
            end
            aems_pkg::S_ROUND:
            begin
                w_next = up_reg ? (minw_reg + q_rounded[15:0])
                                : (minw_reg - q_rounded[15:0]);
            end
            aems_pkg::S_B1:
            begin
                acc_next = prod[32:0] + aems_pkg::ROUND_HALF;
            end
            aems_pkg::S_B2:
            begin
                nx_next = blend_sum[31:16];
            end
            aems_pkg::S_B3:
            begin
                acc_next = prod[32:0] + aems_pkg::ROUND_HALF;
            end
            aems_pkg::S_B4:
            begin
                ny_next = blend_sum[31:16];
            end
            aems_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next     = 1'b1;
                    out_x_next       = nx_reg;
                    out_y_next       = ny_reg;
                    out_w_next       = w_reg;
                    out_ff_next      = ff_reg;
                    stored_x_next    = nx_reg;
                    stored_y_next    = ny_reg;
                    have_stored_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= aems_pkg::S_IDLE;
            have_stored_reg <= 1'b0;
            stored_x_reg    <= '0;
            stored_y_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            have_stored_reg <= have_stored_next;
            stored_x_reg    <= stored_x_next;
            stored_y_reg    <= stored_y_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_reg <= aems_pkg::NOISE_RESET;
            rapid_reg <= aems_pkg::RAPID_RESET;
            minw_reg  <= aems_pkg::MINW_RESET;
            maxw_reg  <= aems_pkg::MAXW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // A transfer to an index beyond the register list is dropped.
            case (cfg_index)
                aems_pkg::CFG_NOISE_THRESHOLD: noise_reg <= cfg_data;
                aems_pkg::CFG_RAPID_THRESHOLD: rapid_reg <= cfg_data;
                aems_pkg::CFG_MIN_WEIGHT:      minw_reg  <= cfg_data;
                aems_pkg::CFG_MAX_WEIGHT:      maxw_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        acc_reg    <= acc_next;
        den_reg    <= den_next;
        up_reg     <= up_next;
        w_reg      <= w_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        ff_reg     <= ff_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        out_w_reg  <= out_w_next;
        out_ff_reg <= out_ff_next;
    end

    // ------------------------------------------------------------------------
    // Shared arithmetic.
    // ------------------------------------------------------------------------
    aems_mul u_mul
    (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    aems_shsub u_shsub
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (unit_cmd),
        .opnd      (unit_opnd),
        .divisor   (den_reg),
        .result    (unit_res),
        .remainder (unit_rem),
        .status    (unit_status)
    );

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {out_w_reg, out_y_reg, out_x_reg};
    assign m_axis_tuser  = out_ff_reg;

endmodule
